>>> hdl/vbpc_pkg.sv
// Shared types and constants for the video beam position counter.
package vbpc_pkg;

    // Field widths
    localparam int TICK_W   = 20;
    localparam int COL_W    = 10;
    localparam int LINE_W   = 11;
    localparam int FRAME_W  = 32;
    localparam int LEN_W    = 9;
    localparam int FLINES_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LINES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_END     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_FRAME_TGL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LINE_TGL  = 3'd4;

    // Register reset values
    localparam logic [LEN_W-1:0]    RST_LINE_LENGTH = 9'd227;
    localparam logic [FLINES_W-1:0] RST_FRAME_LINES = 10'd312;
    localparam logic [FLINES_W-1:0] RST_VBLANK_END  = 10'd25;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // take the tick count of an accepted word
        logic step;    // advance over one line (or the last part of one)
        logic finish;  // capture the result word and the blank state
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ticks_zero;
    } t_dp_status;

    // One result word
    typedef struct packed {
        logic [COL_W-1:0]   beam_column;
        logic [LINE_W-1:0]  beam_line;
        logic [FRAME_W-1:0] frame_number;
        logic               long_frame;
        logic               long_line;
        logic               vblank_now;
        logic               vblank_entered;
        logic               vblank_exited;
    } t_result;

endpackage

>>> hdl/vbpc_ctrl.sv
// Controller: sequences one step per line crossed and owns the output handshake.
module vbpc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  vbpc_pkg::t_dp_status  i_status,
    output vbpc_pkg::t_dp_cmd     o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_status.ticks_zero) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output word valid: set on finish, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/vbpc_dp.sv
// Datapath: configuration registers, beam state, line-step unit and result register.
module vbpc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vbpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vbpc_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic [vbpc_pkg::TICK_W-1:0]       i_tick_count,
    input  vbpc_pkg::t_dp_cmd                 i_cmd,
    output vbpc_pkg::t_dp_status              o_status,
    output vbpc_pkg::t_result                 o_result
);

    // Configuration
    logic [vbpc_pkg::LEN_W-1:0]    r_line_length;
    logic [vbpc_pkg::FLINES_W-1:0] r_frame_lines;
    logic [vbpc_pkg::FLINES_W-1:0] r_vblank_end;
    logic                          r_lf_tgl_en;
    logic                          r_ll_tgl_en;

    // Beam state
    logic [vbpc_pkg::TICK_W-1:0]  r_ticks, n_ticks;
    logic [vbpc_pkg::COL_W-1:0]   r_column, n_column;
    logic [vbpc_pkg::LINE_W-1:0]  r_line, n_line;
    logic [vbpc_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic                         r_long_frame, n_long_frame;
    logic                         r_long_line, n_long_line;
    logic                         r_vblank;
    vbpc_pkg::t_result            r_result;

    // Step logic
    logic [vbpc_pkg::LEN_W-1:0]  len_eff;
    logic [vbpc_pkg::COL_W-1:0]  line_lim;
    logic [vbpc_pkg::COL_W-1:0]  room;
    logic [vbpc_pkg::LINE_W-1:0] frame_lim;
    logic [vbpc_pkg::LINE_W-1:0] line_inc;
    logic                        col_at_end;
    logic                        ticks_fit;
    logic                        do_end_line;
    logic                        ll_toggled;
    logic                        vb_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= vbpc_pkg::RST_LINE_LENGTH;
            r_frame_lines <= vbpc_pkg::RST_FRAME_LINES;
            r_vblank_end  <= vbpc_pkg::RST_VBLANK_END;
            r_lf_tgl_en   <= 1'b0;
            r_ll_tgl_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vbpc_pkg::CFG_LINE_LENGTH:    r_line_length <= i_cfg_data[vbpc_pkg::LEN_W-1:0];
                vbpc_pkg::CFG_FRAME_LINES:    r_frame_lines <= i_cfg_data;
                vbpc_pkg::CFG_VBLANK_END:     r_vblank_end  <= i_cfg_data;
                vbpc_pkg::CFG_LONG_FRAME_TGL: r_lf_tgl_en   <= i_cfg_data[0];
                vbpc_pkg::CFG_LONG_LINE_TGL:  r_ll_tgl_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Line and frame limits; a zero line length counts as one
    assign len_eff    = (r_line_length == '0) ? vbpc_pkg::LEN_W'(1) : r_line_length;
    assign line_lim   = {1'b0, len_eff} + vbpc_pkg::COL_W'(r_long_line);
    assign frame_lim  = {1'b0, r_frame_lines} + vbpc_pkg::LINE_W'(r_long_frame);
    assign col_at_end = (r_column >= line_lim);
    assign room       = line_lim - r_column;
    assign ticks_fit  = (r_ticks < {{(vbpc_pkg::TICK_W-vbpc_pkg::COL_W){1'b0}}, room});
    assign line_inc   = r_line + vbpc_pkg::LINE_W'(1);
    assign ll_toggled = r_ll_tgl_en ? ~r_long_line : r_long_line;

    // One step: finish the current line or stop inside it
    always_comb begin
        n_ticks      = r_ticks;
        n_column     = r_column;
        n_line       = r_line;
        n_frame      = r_frame;
        n_long_frame = r_long_frame;
        n_long_line  = r_long_line;
        do_end_line  = 1'b0;
        if (i_cmd.load) begin
            n_ticks = i_tick_count;
        end else if (i_cmd.step) begin
            if (col_at_end) begin
                // column left past the line end by a register write
                do_end_line = 1'b1;
            end else if (ticks_fit) begin
                n_column = r_column + r_ticks[vbpc_pkg::COL_W-1:0];
                n_ticks  = '0;
            end else begin
                n_ticks     = r_ticks - {{(vbpc_pkg::TICK_W-vbpc_pkg::COL_W){1'b0}}, room};
                do_end_line = 1'b1;
            end
            if (do_end_line) begin
                n_column = '0;
                if (line_inc >= frame_lim) begin
                    n_line       = '0;
                    n_frame      = r_frame + vbpc_pkg::FRAME_W'(1);
                    n_long_frame = r_lf_tgl_en ? ~r_long_frame : r_long_frame;
                    n_long_line  = r_ll_tgl_en ? ll_toggled : 1'b0;
                end else begin
                    n_line      = line_inc;
                    n_long_line = ll_toggled;
                end
            end
        end
    end

    assign vb_now = (r_line < {1'b0, r_vblank_end});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks      <= '0;
            r_column     <= '0;
            r_line       <= '0;
            r_frame      <= '0;
            r_long_frame <= 1'b0;
            r_long_line  <= 1'b0;
            r_vblank     <= 1'b1;
        end else begin
            r_ticks      <= n_ticks;
            r_column     <= n_column;
            r_line       <= n_line;
            r_frame      <= n_frame;
            r_long_frame <= n_long_frame;
            r_long_line  <= n_long_line;
            if (i_cmd.finish) begin
                r_vblank <= vb_now;
            end
        end
    end

    // Result word, blank edges against the state left by the previous word
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.beam_column    <= r_column;
            r_result.beam_line      <= r_line;
            r_result.frame_number   <= r_frame;
            r_result.long_frame     <= r_long_frame;
            r_result.long_line      <= r_long_line;
            r_result.vblank_now     <= vb_now;
            r_result.vblank_entered <= !r_vblank && vb_now;
            r_result.vblank_exited  <= r_vblank && !vb_now;
        end
    end

    assign o_status.ticks_zero = (r_ticks == '0);
    assign o_result            = r_result;

endmodule

>>> hdl/video_beam_position_counter.sv
// Top level of the video beam position counter.
//
// Input stream (s_axis): each word carries a tick count; the beam moves that
// many ticks through lines and frames. Output stream (m_axis): one result
// word per input word with column, line, frame number, long-frame and
// long-line flags, and the vertical blank state with its entry/exit edges.
// Configuration channel (cfg): index/data writes to line length, frame
// lines, blank end line and the two toggle enables; always ready. The user
// must write it only while no word is in flight; the block does not enforce it.
// Timing: the step unit crosses one line end per cycle. A word is stepped
// until its ticks are used up (the last step stops inside a line when the
// ticks end there); once the output register is free, the result word is
// registered and the controller returns to idle, where the next word is
// accepted. A new word is not taken before the current one has finished.
// Reset: synchronous, active low; registers take their default values, the
// beam is at column 0, line 0, frame 0, inside vertical blank.
// Stall: a result not taken waits in the output register; the next word is
// still accepted and computed, and then holds until the register frees.
module video_beam_position_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // s_axis tdata: [19:0] tick_count, [23:20] zero
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [vbpc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // m_axis tdata: [9:0] beam_column, [20:10] beam_line, [52:21] frame_number,
    // [53] long_frame, [54] long_line, [55] vblank_now, [56] vblank_entered,
    // [57] vblank_exited, [63:58] zero
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [vbpc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vbpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vbpc_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    vbpc_pkg::t_dp_cmd    cmd;
    vbpc_pkg::t_dp_status status;
    vbpc_pkg::t_result    result;

    assign o_cfg_ready = 1'b1;

    vbpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    vbpc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_tick_count (i_s_axis_tdata[vbpc_pkg::TICK_W-1:0]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_result     (result)
    );

    // Pack the result word, first field lowest
    assign o_m_axis_tdata = {6'b0,
                             result.vblank_exited,
                             result.vblank_entered,
                             result.vblank_now,
                             result.long_line,
                             result.long_frame,
                             result.frame_number,
                             result.beam_line,
                             result.beam_column};

endmodule

>>> hdl/vbpc_checker.sv
// Port-level checks for the video beam position counter, bound to the top level.
module vbpc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [vbpc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    // Reset leaves no result word pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result word valid right after reset");

    // A stalled result word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // Blank edges agree with the blank state and never both fire
    a_edge_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[56] && !o_m_axis_tdata[55])
                         && !(o_m_axis_tdata[57] && o_m_axis_tdata[55]))
        else $error("blank edge contradicts blank state");

    // A result never appears in the cycle right after its input is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result word faster than the step unit allows");

endmodule

bind video_beam_position_counter vbpc_checker u_vbpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
